// ===== rtl/core/lobm_pkg.sv =====
`default_nettype none
package lobm_pkg;

  localparam int ID_W  = 31;
  localparam int TR_W  = 16;
  localparam int PX_W  = 16;
  localparam int QT_W  = 24;
  localparam int ARR_W = 32;

  localparam logic CMD_NEW    = 1'b0;
  localparam logic CMD_CANCEL = 1'b1;
  localparam logic SIDE_BUY   = 1'b0;
  localparam logic SIDE_SELL  = 1'b1;

  typedef enum logic [2:0] {
    KIND_TRADE     = 3'd0,
    KIND_RESTED    = 3'd1,
    KIND_FILLED    = 3'd2,
    KIND_DROPPED   = 3'd3,
    KIND_CANCELLED = 3'd4,
    KIND_NOTFOUND  = 3'd5
  } kind_t;

  // classified input item, as it sits in the command queue
  typedef struct packed {
    logic            is_cancel;
    logic [ID_W-1:0] ord_ref;
    logic [TR_W-1:0] acct_id;
    logic            side;
    logic [PX_W-1:0] limit_price;
    logic [QT_W-1:0] quantity;
  } item_t;

  // one resting order, one book memory word
  typedef struct packed {
    logic [ID_W-1:0]  ord_ref;
    logic [TR_W-1:0]  trader;
    logic             side;
    logic [PX_W-1:0]  price;
    logic [QT_W-1:0]  remaining;
    logic [ARR_W-1:0] arrival;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);

  typedef struct packed {
    kind_t           kind;
    logic [ID_W-1:0] buy_order_id;
    logic [ID_W-1:0] sell_order_id;
    logic [TR_W-1:0] buyer_id;
    logic [TR_W-1:0] seller_id;
    logic [QT_W-1:0] fill_quantity;
    logic [PX_W-1:0] fill_price;
    logic            order_side;
    logic            last;
  } result_t;

endpackage
`default_nettype wire

// ===== rtl/core/limit_order_book_matcher_core.sv =====
`default_nettype none
// channel | valid     | stall     | payload
// input   | in_valid  | in_stall  | cmd ord_ref acct_id side limit_price quantity
// output  | out_valid | out_stall | kind ids traders fill_quantity fill_price order_side last
//
// Every book search is one pass over all ORDER_SLOTS entries of the book
// memory at one entry per cycle, followed by a decision step. An order that
// ends with F fills makes F searches, one that rests or is dropped makes
// F + 1, a cancel makes one and a zero quantity none; a taken transfer is
// written into the command queue before the engine can dequeue it.
// Reset clears the valid bits, the arrival counter and all control; the book
// memory itself is not cleared. A stalled output holds the engine; the
// two-entry command queue keeps taking transfers until full.
module limit_order_book_matcher_core #(
  parameter int ORDER_SLOTS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        cmd,
  input  wire logic [30:0] ord_ref,
  input  wire logic [15:0] acct_id,
  input  wire logic        side,
  input  wire logic [15:0] limit_price,
  input  wire logic [23:0] quantity,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       kind,
  output logic [30:0]      buy_order_id,
  output logic [30:0]      sell_order_id,
  output logic [15:0]      buyer_id,
  output logic [15:0]      seller_id,
  output logic [23:0]      fill_quantity,
  output logic [15:0]      fill_price,
  output logic             order_side,
  output logic             last
);
  import lobm_pkg::*;

  logic    q_valid;
  item_t   q_item;
  logic    q_pop;
  result_t res;

  // front: accepts transfers, tags cancels, queues them
  lobm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .cmd        (cmd),
    .ord_ref    (ord_ref),
    .acct_id    (acct_id),
    .side       (side),
    .limit_price(limit_price),
    .quantity   (quantity),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop)
  );

  // back: book search, fills, resting and cancels, output register
  lobm_engine #(
    .ORDER_SLOTS(ORDER_SLOTS)
  ) u_engine (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop),
    .res_valid(out_valid),
    .res      (res),
    .out_stall(out_stall)
  );

  assign kind          = res.kind;
  assign buy_order_id  = res.buy_order_id;
  assign sell_order_id = res.sell_order_id;
  assign buyer_id      = res.buyer_id;
  assign seller_id     = res.seller_id;
  assign fill_quantity = res.fill_quantity;
  assign fill_price    = res.fill_price;
  assign order_side    = res.order_side;
  assign last          = res.last;

  // trades are never the closing result
  a_trade_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_TRADE |-> !last)
    else $error("trade flagged as last");

  // status results always close the item
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != KIND_TRADE |-> last)
    else $error("status result not last");

  a_notfound_ids: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_NOTFOUND |-> buy_order_id == sell_order_id)
    else $error("cancel miss ids differ");

  a_filled_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_FILLED |-> fill_quantity == 24'd0)
    else $error("filled result with quantity");

endmodule
`default_nettype wire

// ===== rtl/core/lobm_ram.sv =====
`default_nettype none
module lobm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/core/lobm_front.sv =====
`default_nettype none
module lobm_front (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic                    cmd,
  input  wire logic [30:0]             ord_ref,
  input  wire logic [15:0]             acct_id,
  input  wire logic                    side,
  input  wire logic [15:0]             limit_price,
  input  wire logic [23:0]             quantity,
  output logic                         q_valid,
  output lobm_pkg::item_t              q_item,
  input  wire logic                    q_pop
);
  import lobm_pkg::*;

  // two-entry command queue
  item_t      mem [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;
  logic       push;
  item_t      item_in;

  assign in_stall = (cnt == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt != 2'd0);
  assign q_item   = mem[rp];

  always_comb begin
    item_in.is_cancel   = (cmd == CMD_CANCEL);
    item_in.ord_ref     = ord_ref;
    item_in.acct_id     = acct_id;
    item_in.side        = side;
    item_in.limit_price = limit_price;
    item_in.quantity    = quantity;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (q_pop) begin
        rp <= ~rp;
      end
      cnt <= cnt + {1'b0, push} - {1'b0, q_pop};
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/lobm_engine.sv =====
`default_nettype none
module lobm_engine #(
  parameter int ORDER_SLOTS = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 q_valid,
  input  wire lobm_pkg::item_t      q_item,
  output logic                      q_pop,
  output logic                      res_valid,
  output lobm_pkg::result_t         res,
  input  wire logic                 out_stall
);
  import lobm_pkg::*;

  localparam int AW = $clog2(ORDER_SLOTS);
  localparam logic [AW-1:0] LAST_IDX = AW'(ORDER_SLOTS - 1);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SCAN   = 5'b00010,
    S_DECIDE = 5'b00100,
    S_TRADE  = 5'b01000,
    S_STATUS = 5'b10000
  } state_t;

  state_t           state;
  item_t            cur;
  logic [QT_W-1:0]  qty;
  kind_t            st_kind;
  logic [ORDER_SLOTS-1:0] slot_valid;
  logic [ARR_W-1:0] arrival_ctr;

  logic [AW-1:0]    ra;
  logic             issuing;
  logic             pv;
  logic [AW-1:0]    pidx;
  logic             vq;

  logic             best_found;
  logic [AW-1:0]    best_idx;
  slot_t            best;
  logic [ARR_W-1:0] best_age;
  logic             free_found;
  logic [AW-1:0]    free_idx;

  logic              we;
  logic [AW-1:0]     waddr;
  slot_t             wslot;
  logic [SLOT_W-1:0] rdata;
  slot_t             rd;

  logic             can_emit;
  logic [ARR_W-1:0] age_i;
  logic             cand;
  logic             better;
  logic             take;
  logic [QT_W-1:0]  amt;
  logic [QT_W-1:0]  new_rem;
  logic [QT_W-1:0]  qty_left;
  result_t          trade_r;
  result_t          status_r;

  lobm_ram #(
    .WIDTH(SLOT_W),
    .DEPTH(ORDER_SLOTS)
  ) u_book (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wslot),
    .raddr(ra),
    .rdata(rdata)
  );

  assign rd       = slot_t'(rdata);
  assign can_emit = !res_valid || !out_stall;
  assign q_pop    = (state == S_IDLE) && q_valid;

  // scan compare
  always_comb begin
    age_i = arrival_ctr - rd.arrival;
    if (cur.is_cancel) begin
      cand   = vq && (rd.ord_ref == cur.ord_ref);
      better = !best_found || (age_i > best_age);
    end else begin
      cand = vq && (rd.side != cur.side) &&
             ((cur.side == SIDE_BUY) ? (cur.limit_price >= rd.price)
                                     : (cur.limit_price <= rd.price));
      if (!best_found) begin
        better = 1'b1;
      end else if (rd.price != best.price) begin
        better = (cur.side == SIDE_BUY) ? (rd.price < best.price) : (rd.price > best.price);
      end else begin
        better = age_i > best_age;
      end
    end
    take = (state == S_SCAN) && pv && cand && better;
  end

  // fill against the chosen resting order
  always_comb begin
    amt      = (qty < best.remaining) ? qty : best.remaining;
    new_rem  = best.remaining - amt;
    qty_left = qty - amt;
    trade_r.kind          = KIND_TRADE;
    trade_r.fill_quantity = amt;
    trade_r.fill_price    = best.price;
    trade_r.order_side    = cur.side;
    trade_r.last          = 1'b0;
    if (cur.side == SIDE_BUY) begin
      trade_r.buy_order_id  = cur.ord_ref;
      trade_r.sell_order_id = best.ord_ref;
      trade_r.buyer_id      = cur.acct_id;
      trade_r.seller_id     = best.trader;
    end else begin
      trade_r.buy_order_id  = best.ord_ref;
      trade_r.sell_order_id = cur.ord_ref;
      trade_r.buyer_id      = best.trader;
      trade_r.seller_id     = cur.acct_id;
    end
  end

  // closing result of an item
  always_comb begin
    logic [ID_W-1:0] id;
    logic [TR_W-1:0] tr;
    logic            sd;
    id = cur.ord_ref;
    tr = cur.acct_id;
    sd = cur.side;
    status_r.kind          = st_kind;
    status_r.fill_quantity = qty;
    status_r.fill_price    = cur.limit_price;
    status_r.last          = 1'b1;
    case (st_kind)
      KIND_FILLED: begin
        status_r.fill_quantity = '0;
      end
      KIND_CANCELLED: begin
        tr = best.trader;
        sd = best.side;
        status_r.fill_quantity = best.remaining;
        status_r.fill_price    = best.price;
      end
      KIND_NOTFOUND: begin
        tr = '0;
        sd = SIDE_BUY;
        status_r.fill_quantity = '0;
        status_r.fill_price    = '0;
      end
      default: begin
      end
    endcase
    status_r.order_side = sd;
    if (st_kind == KIND_NOTFOUND) begin
      status_r.buy_order_id  = id;
      status_r.sell_order_id = id;
      status_r.buyer_id      = '0;
      status_r.seller_id     = '0;
    end else if (sd == SIDE_BUY) begin
      status_r.buy_order_id  = id;
      status_r.sell_order_id = '0;
      status_r.buyer_id      = tr;
      status_r.seller_id     = '0;
    end else begin
      status_r.buy_order_id  = '0;
      status_r.sell_order_id = id;
      status_r.buyer_id      = '0;
      status_r.seller_id     = tr;
    end
  end

  // book writes
  always_comb begin
    we    = 1'b0;
    waddr = best_idx;
    wslot = best;
    if (state == S_TRADE && can_emit) begin
      we              = 1'b1;
      wslot.remaining = new_rem;
    end else if (state == S_STATUS && can_emit && st_kind == KIND_RESTED) begin
      we              = 1'b1;
      waddr           = free_idx;
      wslot.ord_ref   = cur.ord_ref;
      wslot.trader    = cur.acct_id;
      wslot.side      = cur.side;
      wslot.price     = cur.limit_price;
      wslot.remaining = qty;
      wslot.arrival   = arrival_ctr;
    end
  end

  always_ff @(posedge clk) begin
    pidx <= ra;
    vq   <= slot_valid[ra];
    if (take) begin
      best_idx <= pidx;
      best     <= rd;
      best_age <= age_i;
    end
    if (state == S_SCAN && pv && !vq && !free_found) begin
      free_idx <= pidx;
    end
    if (state == S_TRADE && can_emit) begin
      best.remaining <= new_rem;
    end
    if (q_pop) begin
      cur <= q_item;
    end
    if ((state == S_TRADE || state == S_STATUS) && can_emit) begin
      res <= (state == S_TRADE) ? trade_r : status_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      slot_valid  <= '0;
      arrival_ctr <= '0;
      res_valid   <= 1'b0;
      issuing     <= 1'b0;
      pv          <= 1'b0;
      ra          <= '0;
      best_found  <= 1'b0;
      free_found  <= 1'b0;
      qty         <= '0;
      st_kind     <= KIND_FILLED;
    end else begin
      if ((state == S_TRADE || state == S_STATUS) && can_emit) begin
        res_valid <= 1'b1;
      end else if (res_valid && !out_stall) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            qty        <= q_item.quantity;
            ra         <= '0;
            issuing    <= 1'b1;
            pv         <= 1'b0;
            best_found <= 1'b0;
            free_found <= 1'b0;
            if (!q_item.is_cancel && q_item.quantity == '0) begin
              st_kind <= KIND_FILLED;
              issuing <= 1'b0;
              state   <= S_STATUS;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (issuing) begin
            ra <= ra + AW'(1);
            if (ra == LAST_IDX) begin
              issuing <= 1'b0;
            end
          end
          pv <= issuing;
          if (take) begin
            best_found <= 1'b1;
          end
          if (pv && !vq) begin
            free_found <= 1'b1;
          end
          if (pv && pidx == LAST_IDX) begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          pv <= 1'b0;
          if (cur.is_cancel) begin
            st_kind <= best_found ? KIND_CANCELLED : KIND_NOTFOUND;
            state   <= S_STATUS;
          end else if (best_found) begin
            state <= S_TRADE;
          end else begin
            st_kind <= free_found ? KIND_RESTED : KIND_DROPPED;
            state   <= S_STATUS;
          end
        end
        S_TRADE: begin
          if (can_emit) begin
            qty <= qty_left;
            if (new_rem == '0) begin
              slot_valid[best_idx] <= 1'b0;
            end
            if (qty_left == '0) begin
              st_kind <= KIND_FILLED;
              state   <= S_STATUS;
            end else begin
              ra         <= '0;
              issuing    <= 1'b1;
              best_found <= 1'b0;
              free_found <= 1'b0;
              state      <= S_SCAN;
            end
          end
        end
        S_STATUS: begin
          if (can_emit) begin
            if (st_kind == KIND_RESTED) begin
              slot_valid[free_idx] <= 1'b1;
              arrival_ctr          <= arrival_ctr + ARR_W'(1);
            end else if (st_kind == KIND_CANCELLED) begin
              slot_valid[best_idx] <= 1'b0;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== sim/lobm_checker.sv =====
module lobm_checker #(
  parameter int ORDER_SLOTS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        cmd,
  input  logic [30:0] ord_ref,
  input  logic [15:0] acct_id,
  input  logic        side,
  input  logic [15:0] limit_price,
  input  logic [23:0] quantity,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [2:0]  kind,
  input  logic [30:0] buy_order_id,
  input  logic [30:0] sell_order_id,
  input  logic [15:0] buyer_id,
  input  logic [15:0] seller_id,
  input  logic [23:0] fill_quantity,
  input  logic [15:0] fill_price,
  input  logic        order_side,
  input  logic        last,
  output int          errors,
  output int          pending
);
  import lobm_pkg::*;

  localparam int EXP_DEPTH = 1024;

  logic            bk_valid [ORDER_SLOTS];
  logic [ID_W-1:0] bk_id    [ORDER_SLOTS];
  logic [TR_W-1:0] bk_tr    [ORDER_SLOTS];
  logic            bk_side  [ORDER_SLOTS];
  logic [PX_W-1:0] bk_px    [ORDER_SLOTS];
  logic [QT_W-1:0] bk_rem   [ORDER_SLOTS];
  logic [31:0]     bk_arr   [ORDER_SLOTS];
  logic [31:0]     arr_cnt;
  result_t         exp_q    [EXP_DEPTH];
  int              q_head;
  int              q_tail;

  assign pending = q_tail - q_head;

  function automatic result_t mk(kind_t k, logic [30:0] b, logic [30:0] s, logic [15:0] bt,
                                 logic [15:0] st, logic [23:0] q, logic [15:0] p,
                                 logic sd);
    result_t r;
    r.kind = k; r.buy_order_id = b; r.sell_order_id = s; r.buyer_id = bt;
    r.seller_id = st; r.fill_quantity = q; r.fill_price = p; r.order_side = sd;
    r.last = 1'b0;
    return r;
  endfunction

  function automatic result_t own(kind_t k, logic [30:0] id, logic [15:0] tr,
                                  logic [23:0] q, logic [15:0] p, logic sd);
    if (sd == SIDE_BUY) return mk(k, id, 0, tr, 0, q, p, sd);
    return mk(k, 0, id, 0, tr, q, p, sd);
  endfunction

  task automatic queue_result(result_t r);
    exp_q[q_tail % EXP_DEPTH] = r;
    q_tail++;
  endtask

  // opposite-side slot with best price, oldest first on ties; -1 if none crosses
  function automatic int best_contra(logic sd, logic [15:0] lim);
    int b;
    b = -1;
    for (int i = 0; i < ORDER_SLOTS; i++) begin
      if (!bk_valid[i] || bk_side[i] == sd) continue;
      if (sd == SIDE_BUY ? lim < bk_px[i] : lim > bk_px[i]) continue;
      if (b < 0) b = i;
      else if (bk_px[i] != bk_px[b]) begin
        if (sd == SIDE_BUY ? bk_px[i] < bk_px[b] : bk_px[i] > bk_px[b]) b = i;
      end else if (32'(arr_cnt - bk_arr[i]) > 32'(arr_cnt - bk_arr[b])) b = i;
    end
    return b;
  endfunction

  task automatic book_step();
    result_t r;
    int b, f;
    logic [23:0] q, amt;
    if (cmd == CMD_CANCEL) begin
      f = -1;
      for (int i = 0; i < ORDER_SLOTS; i++)
        if (bk_valid[i] && bk_id[i] == ord_ref &&
            (f < 0 || 32'(arr_cnt - bk_arr[i]) > 32'(arr_cnt - bk_arr[f]))) f = i;
      if (f < 0) r = mk(KIND_NOTFOUND, ord_ref, ord_ref, 0, 0, 0, 0, 0);
      else begin
        bk_valid[f] = 0;
        r = own(KIND_CANCELLED, ord_ref, bk_tr[f], bk_rem[f], bk_px[f], bk_side[f]);
      end
    end else begin
      q = quantity;
      while (q > 0) begin
        b = best_contra(side, limit_price);
        if (b < 0) break;
        amt = q < bk_rem[b] ? q : bk_rem[b];
        q -= amt;
        bk_rem[b] -= amt;
        if (side == SIDE_BUY)
          queue_result(mk(KIND_TRADE, ord_ref, bk_id[b], acct_id, bk_tr[b],
                          amt, bk_px[b], side));
        else
          queue_result(mk(KIND_TRADE, bk_id[b], ord_ref, bk_tr[b], acct_id,
                          amt, bk_px[b], side));
        if (bk_rem[b] == 0) bk_valid[b] = 0;
      end
      if (q == 0) r = own(KIND_FILLED, ord_ref, acct_id, 0, limit_price, side);
      else begin
        f = -1;
        for (int i = 0; i < ORDER_SLOTS; i++)
          if (f < 0 && !bk_valid[i]) f = i;
        if (f < 0) r = own(KIND_DROPPED, ord_ref, acct_id, q, limit_price, side);
        else begin
          bk_valid[f] = 1; bk_id[f] = ord_ref; bk_tr[f] = acct_id;
          bk_side[f] = side; bk_px[f] = limit_price; bk_rem[f] = q;
          bk_arr[f] = arr_cnt; arr_cnt++;
          r = own(KIND_RESTED, ord_ref, acct_id, q, limit_price, side);
        end
      end
    end
    r.last = 1'b1;
    queue_result(r);
  endtask

  always @(posedge clk) begin
    result_t got, want;
    if (rst) begin
      for (int i = 0; i < ORDER_SLOTS; i++) bk_valid[i] = 0;
      arr_cnt = 0;
      errors = 0;
      q_head = 0;
      q_tail = 0;
    end else begin
      if (out_valid && !out_stall) begin
        got = {kind_t'(kind), buy_order_id, sell_order_id, buyer_id, seller_id,
               fill_quantity, fill_price, order_side, last};
        if (q_tail == q_head) begin
          errors++;
          if (errors <= 10) $display("unexpected result %h", got);
        end else begin
          want = exp_q[q_head % EXP_DEPTH];
          q_head++;
          if (got !== want) begin
            errors++;
            if (errors <= 10) $display("mismatch: expected %h got %h", want, got);
          end
        end
      end
      if (in_valid && !in_stall) book_step();
    end
  end
endmodule

// ===== sim/tb.sv =====
module tb;
  import lobm_pkg::*;

  logic        clk, rst;
  logic        in_valid = 0, in_stall;
  logic        cmd = 0;
  logic [30:0] ord_ref = 0;
  logic [15:0] acct_id = 0;
  logic        side = 0;
  logic [15:0] limit_price = 0;
  logic [23:0] quantity = 0;
  logic        out_valid, out_stall = 0;
  logic [2:0]  kind;
  logic [30:0] buy_order_id, sell_order_id;
  logic [15:0] buyer_id, seller_id, fill_price;
  logic [23:0] fill_quantity;
  logic        order_side, last;
  int          errors, pending;
  bit          calm;              // no-idle stretch for both sides
  logic [30:0] live_ids [512];    // ids submitted so far, for realistic cancels
  int          n_live = 0;

  limit_order_book_matcher_core uut (.*);
  lobm_checker chk (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // receiver: stalls ~7% of cycles except in calm stretches
  always @(negedge clk) out_stall <= !calm && ($urandom_range(99) < 7);

  // one transfer; valid held until accepted, sometimes a random idle gap afterwards
  task automatic send(logic c, logic [30:0] id, logic [15:0] tr, logic sd,
                      logic [15:0] px, logic [23:0] q);
    cmd <= c; ord_ref <= id; acct_id <= tr; side <= sd;
    limit_price <= px; quantity <= q; in_valid <= 1;
    if (n_live < 512) begin
      live_ids[n_live] = id;
      n_live++;
    end
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    if (!calm && $urandom_range(99) < 7) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  initial begin
    int n;
    logic [15:0] mid;
    calm = 0;
    rst = 1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed: extremes, each result kind, zero qty, ties, self-trade
    send(CMD_CANCEL, 31'h7fffffff, 0, 0, 0, 0);            // cancel not found
    send(CMD_NEW, 1, 16'hffff, SIDE_BUY, 0, 0);            // zero quantity
    send(CMD_NEW, 2, 7, SIDE_SELL, 100, 10);
    send(CMD_NEW, 3, 8, SIDE_SELL, 100, 5);                // same price, later
    send(CMD_NEW, 4, 9, SIDE_SELL, 90, 3);
    send(CMD_NEW, 5, 7, SIDE_BUY, 16'hffff, 12);           // sweeps 4 then 2
    send(CMD_NEW, 3, 1, SIDE_SELL, 16'hffff, 24'hffffff);  // duplicate id rests
    send(CMD_CANCEL, 3, 0, 0, 0, 0);                       // older id 3 removed
    send(CMD_CANCEL, 3, 0, 0, 0, 0);
    send(CMD_NEW, 31'h7fffffff, 16'hffff, SIDE_BUY, 16'hffff, 24'hffffff);
    send(CMD_NEW, 6, 7, SIDE_SELL, 0, 1);                  // sell vs resting buy, full trade
    send(CMD_CANCEL, 31'h7fffffff, 0, 0, 0, 0);            // clear the big buy
    for (int i = 0; i < 33; i++)                           // fill book then drop
      send(CMD_NEW, 31'(100 + i), 16'(i), SIDE_SELL, 16'hfff0, 24'h00ffff);
    drain();  // sender holds off until every result is back
    send(CMD_NEW, 200, 2, SIDE_BUY, 16'hffff, 24'hffffff); // sweep all slots
    drain();

    // random: prices clustered so orders cross; some noise
    n = 0;
    while (n < 110) begin
      calm = (n >= 40 && n < 80);
      mid = 16'(1000 + $urandom_range(0, 20));
      if ($urandom_range(99) < 20 && n_live > 0)
        send(CMD_CANCEL, $urandom_range(9) == 0 ? 31'($urandom) :
             live_ids[$urandom_range(n_live - 1)], 16'($urandom),
             1'($urandom), 16'($urandom), 24'($urandom));
      else if ($urandom_range(99) < 5)
        send(CMD_NEW, 31'($urandom), 16'($urandom), 1'($urandom),
             16'($urandom), 24'($urandom));
      else
        send(CMD_NEW, 31'($urandom_range(300, 400)), 16'($urandom), 1'($urandom), mid,
             $urandom_range(99) < 5 ? 24'hffffff : 24'($urandom_range(0, 50)));
      n++;
    end
    calm = 0;
    drain();
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #20000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule

// ===== limit_order_book_matcher_core.f =====
rtl/core/lobm_pkg.sv
rtl/core/lobm_ram.sv
rtl/core/lobm_front.sv
rtl/core/lobm_engine.sv
rtl/core/limit_order_book_matcher_core.sv
sim/lobm_checker.sv
sim/tb.sv
